// File: hdl/peer_presence_aging_table_assert.svh
// Assertion macros for the peer presence aging table checker.
// Used by the checker module only; no other dependencies.
`ifndef PEER_PRESENCE_AGING_TABLE_ASSERT_SVH
`define PEER_PRESENCE_AGING_TABLE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define PPAT_ASSERT_IMP(lbl, clk, rst_n, lhs, rhs) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("assertion failed");

// Implication whose consequence is checked in the cycle after the antecedent.
`define PPAT_ASSERT_NEXT(lbl, clk, rst_n, lhs, rhs) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("assertion failed");

`endif

// File: hdl/ppat_pkg.sv
// Shared types and constants of the peer presence aging table.
// No dependencies.
package ppat_pkg;

  localparam int MaxPeers   = 64;
  localparam int KeyBits    = 256;
  localparam int IdxW       = $clog2(MaxPeers);
  localparam int CntW       = $clog2(MaxPeers + 1);
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 16;
  localparam logic [31:0] TypingWindow = 32'd5;

  typedef enum logic [1:0] {
    CMD_UPDATE = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_EXPIRE = 2'd2,
    CMD_TYPING = 2'd3
  } cmd_e;

  localparam logic [CfgIdxW-1:0] REG_TTL_LOCAL = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_TTL_RELAY = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_LOCAL_TR  = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] key_word0;
    logic [63:0] key_word1;
    logic [63:0] key_word2;
    logic [63:0] key_word3;
    logic [2:0]  presence_code;
    logic [7:0]  transport_code;
    logic [31:0] now_seconds;
  } req_t;

  typedef struct packed {
    logic            found;
    logic [2:0]      presence_out;
    logic            is_online;
    logic            typing_active;
    logic [6:0]      removed_count;
  } rsp_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_t;

  // Controller to datapath
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,     // capture request
    OP_READ,     // issue read of entry at addr2: scan pointer, or last entry for expire move
    OP_WRITE_UPD,// refresh hit entry
    OP_WRITE_NEW,// append new entry
    OP_WRITE_TYP,// set typing mark
    OP_MOVE,     // copy last entry into scan slot
    OP_RESULT    // build result
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [IdxW-1:0] addr;
    logic [IdxW-1:0] addr2;
    logic            hit;   // key matched, or update appended an entry
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] command;
    logic       match;
    logic       aged_relay;
  } sts_t;

endpackage

// File: hdl/ppat_if.sv
// Valid/ready channel interfaces, one per payload type (req, rsp, cfg).
// Depends on ppat_pkg for payload types.
interface ppat_req_if (input logic clk_i);
  logic            valid;
  logic            ready;
  ppat_pkg::req_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ppat_rsp_if (input logic clk_i);
  logic            valid;
  logic            ready;
  ppat_pkg::rsp_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ppat_cfg_if (input logic clk_i);
  logic            valid;
  logic            ready;
  ppat_pkg::cfg_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/ppat_datapath.sv
// Datapath: entry memory, request register, config registers, compare logic.
// Depends on ppat_pkg.
module ppat_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ppat_pkg::req_t      req_i,
  input  logic                cfg_we_i,
  input  ppat_pkg::cfg_t      cfg_i,
  input  ppat_pkg::ctl_t      ctl_i,
  input  logic [ppat_pkg::CntW-1:0] removed_i,
  output ppat_pkg::sts_t      sts_o,
  output ppat_pkg::rsp_t      rsp_o
);
  typedef struct packed {
    logic [ppat_pkg::KeyBits-1:0] key;
    logic [2:0]  pres;
    logic [7:0]  trans;
    logic [31:0] seen;
    logic        tmark;
    logic [31:0] tstart;
  } ent_t;

  ent_t mem_q [ppat_pkg::MaxPeers];
  ent_t rd_q;
  ppat_pkg::req_t req_q;
  logic [15:0] ttl_local_q, ttl_relay_q;
  logic [7:0]  local_tr_q;
  logic [ppat_pkg::KeyBits-1:0] key_in;
  logic [31:0] age, tage;
  logic [15:0] ttl_sel;
  ent_t wr_ent;
  ppat_pkg::rsp_t rsp_d;

  assign key_in = ppat_pkg::KeyBits'({req_q.key_word3, req_q.key_word2,
                                      req_q.key_word1, req_q.key_word0});
  assign age     = req_q.now_seconds - rd_q.seen;
  assign tage    = req_q.now_seconds - rd_q.tstart;
  assign ttl_sel = (rd_q.trans == local_tr_q) ? ttl_local_q : ttl_relay_q;

  assign sts_o.command    = req_q.command;
  assign sts_o.match      = (rd_q.key == key_in);
  assign sts_o.aged_relay = (age > {16'd0, ttl_relay_q});

  always_comb begin
    wr_ent = rd_q;
    unique case (ctl_i.op)
      ppat_pkg::OP_WRITE_UPD: begin
        wr_ent.pres  = req_q.presence_code;
        wr_ent.trans = req_q.transport_code;
        wr_ent.seen  = req_q.now_seconds;
      end
      ppat_pkg::OP_WRITE_NEW: begin
        wr_ent.key    = key_in;
        wr_ent.pres   = req_q.presence_code;
        wr_ent.trans  = req_q.transport_code;
        wr_ent.seen   = req_q.now_seconds;
        wr_ent.tmark  = 1'b0;
        wr_ent.tstart = '0;
      end
      ppat_pkg::OP_WRITE_TYP: begin
        wr_ent.tmark  = 1'b1;
        wr_ent.tstart = req_q.now_seconds;
      end
      default: ;
    endcase
  end

  always_comb begin
    rsp_d = '0;
    unique case (ppat_pkg::cmd_e'(req_q.command))
      ppat_pkg::CMD_EXPIRE: rsp_d.removed_count = 7'(removed_i);
      ppat_pkg::CMD_QUERY: begin
        if (ctl_i.hit) begin
          rsp_d.found         = 1'b1;
          rsp_d.presence_out  = (age > {16'd0, ttl_sel}) ? 3'd0 : rd_q.pres;
          rsp_d.is_online     = (rsp_d.presence_out != 3'd0);
          rsp_d.typing_active = rd_q.tmark && (tage <= ppat_pkg::TypingWindow);
        end
      end
      default: rsp_d.found = ctl_i.hit;
    endcase
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    unique case (ctl_i.op)
      ppat_pkg::OP_WRITE_UPD, ppat_pkg::OP_WRITE_NEW, ppat_pkg::OP_WRITE_TYP,
      ppat_pkg::OP_MOVE: mem_q[ctl_i.addr] <= wr_ent;
      default: ;
    endcase
    if (ctl_i.op == ppat_pkg::OP_READ) rd_q <= mem_q[ctl_i.addr2];
    if (ctl_i.op == ppat_pkg::OP_LOAD) req_q <= req_i;
    if (ctl_i.op == ppat_pkg::OP_RESULT) rsp_o <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_local_q <= 16'd60;
      ttl_relay_q <= 16'd300;
      local_tr_q  <= 8'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_i.index)
        ppat_pkg::REG_TTL_LOCAL: ttl_local_q <= cfg_i.data;
        ppat_pkg::REG_TTL_RELAY: ttl_relay_q <= cfg_i.data;
        ppat_pkg::REG_LOCAL_TR:  local_tr_q  <= cfg_i.data[7:0];
        default: ;
      endcase
    end
  end
endmodule

// File: hdl/ppat_ctrl.sv
// Controller: sequences search, update, typing and expire compaction.
// Depends on ppat_pkg.
module ppat_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  ppat_pkg::sts_t      sts_i,
  output ppat_pkg::ctl_t      ctl_o,
  output logic [ppat_pkg::CntW-1:0] removed_o
);
  typedef enum logic [2:0] {
    ST_IDLE, ST_ISSUE, ST_CHECK, ST_WRITE, ST_RESULT, ST_OUT
  } state_e;

  state_e state_q;
  logic [ppat_pkg::CntW-1:0] cnt_q, ptr_q, rem_q;
  logic out_valid_q;
  logic hit_q;
  logic res_free;
  logic [ppat_pkg::IdxW-1:0] ptr_idx, last_idx;

  assign ptr_idx  = ptr_q[ppat_pkg::IdxW-1:0];
  assign last_idx = ppat_pkg::IdxW'(cnt_q - 1'b1);
  // result register may be overwritten once the old result is gone or leaving
  assign res_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign removed_o   = rem_q;

  always_comb begin
    ctl_o = '{op: ppat_pkg::OP_NONE, addr: ptr_idx, addr2: ptr_idx, hit: hit_q};
    unique case (state_q)
      ST_IDLE:   if (in_valid_i && in_ready_o) ctl_o.op = ppat_pkg::OP_LOAD;
      ST_ISSUE:  ctl_o.op = ppat_pkg::OP_READ;
      ST_WRITE: begin
        unique case (ppat_pkg::cmd_e'(sts_i.command))
          ppat_pkg::CMD_UPDATE:
            ctl_o.op = (ptr_q == cnt_q) ? ppat_pkg::OP_WRITE_NEW : ppat_pkg::OP_WRITE_UPD;
          ppat_pkg::CMD_TYPING: ctl_o.op = ppat_pkg::OP_WRITE_TYP;
          default: ctl_o.op = ppat_pkg::OP_MOVE;
        endcase
      end
      ST_RESULT: if (res_free) ctl_o.op = ppat_pkg::OP_RESULT;
      default: ;
    endcase
    // expire move: read last into holding reg, then write to scan slot
    if (state_q == ST_CHECK && sts_i.command == 2'(ppat_pkg::CMD_EXPIRE)
        && sts_i.aged_relay && ptr_idx != last_idx) begin
      ctl_o.op    = ppat_pkg::OP_READ;
      ctl_o.addr2 = last_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ptr_q       <= '0;
      rem_q       <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: if (in_valid_i && in_ready_o) begin
          ptr_q   <= '0;
          rem_q   <= '0;
          hit_q   <= 1'b0;
          state_q <= ST_ISSUE;
        end
        ST_ISSUE: begin
          if (ptr_q >= cnt_q) begin
            // search miss
            priority case (ppat_pkg::cmd_e'(sts_i.command))
              ppat_pkg::CMD_UPDATE:
                state_q <= (cnt_q < ppat_pkg::CntW'(ppat_pkg::MaxPeers)) ? ST_WRITE
                                                                          : ST_RESULT;
              default: state_q <= ST_RESULT;
            endcase
          end else begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (sts_i.command == 2'(ppat_pkg::CMD_EXPIRE)) begin
            if (sts_i.aged_relay) begin
              rem_q <= rem_q + 1'b1;
              cnt_q <= cnt_q - 1'b1;
              state_q <= (ptr_idx != last_idx) ? ST_WRITE : ST_ISSUE;
            end else begin
              ptr_q   <= ptr_q + 1'b1;
              state_q <= ST_ISSUE;
            end
          end else if (sts_i.match) begin
            hit_q   <= 1'b1;
            state_q <= (sts_i.command == 2'(ppat_pkg::CMD_QUERY)) ? ST_RESULT : ST_WRITE;
          end else begin
            ptr_q   <= ptr_q + 1'b1;
            state_q <= ST_ISSUE;
          end
        end
        ST_WRITE: begin
          if (sts_i.command == 2'(ppat_pkg::CMD_UPDATE) && ptr_q == cnt_q) begin
            cnt_q <= cnt_q + 1'b1;
            hit_q <= 1'b1;
          end
          state_q <= (sts_i.command == 2'(ppat_pkg::CMD_EXPIRE)) ? ST_ISSUE : ST_RESULT;
        end
        ST_RESULT: if (res_free) state_q <= ST_OUT;
        ST_OUT: begin
          out_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule

// File: hdl/peer_presence_aging_table.sv
// Top level of the peer presence aging table.
// Depends on ppat_pkg, ppat_if, ppat_ctrl and ppat_datapath.
//
// Channels: req (sink) carries one command with key, presence, transport and
// time; rsp (source) returns one result per command; cfg (sink) writes the
// local TTL, relay TTL and local transport code, always ready.
// Search: each entry visited passes through the ISSUE and CHECK states, which
// read it and compare it. Expire keeps an entry the same way and removes one
// with an added WRITE state (copy of the last entry into the freed slot; no
// copy for the last entry), all through the one write port and one read port
// of the entry memory.
// One command is in flight at a time; req is ready whenever the controller
// is idle, even while the previous result still waits in the result register.
// When the receiver stalls, the result holds, the next command stops before
// writing its own result, and req stays not ready until the old one is taken.
// Reset empties the table (entry count zero) and loads TTL 60/300 and local
// transport 1; entry memory contents are not cleared.
module peer_presence_aging_table (
  input  logic      clk_i,
  input  logic      rst_ni,
  ppat_req_if.sink  req,
  ppat_rsp_if.source rsp,
  ppat_cfg_if.sink  cfg
);
  ppat_pkg::ctl_t ctl;
  ppat_pkg::sts_t sts;
  logic [ppat_pkg::CntW-1:0] removed;

  assign cfg.ready = 1'b1;

  ppat_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (req.valid),
    .in_ready_o (req.ready),
    .out_valid_o(rsp.valid),
    .out_ready_i(rsp.ready),
    .sts_i      (sts),
    .ctl_o      (ctl),
    .removed_o  (removed)
  );

  ppat_datapath u_dp (
    .clk_i, .rst_ni,
    .req_i    (req.data),
    .cfg_we_i (cfg.valid),
    .cfg_i    (cfg.data),
    .ctl_i    (ctl),
    .removed_i(removed),
    .sts_o    (sts),
    .rsp_o    (rsp.data)
  );
endmodule

// File: hdl/ppat_checker.sv
// Port-level checker for the peer presence aging table, bound to the top.
// Depends on peer_presence_aging_table_assert.svh.
`include "peer_presence_aging_table_assert.svh"
module ppat_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        found,
  input logic [2:0]  presence_out,
  input logic        is_online,
  input logic [6:0]  removed_count
);
  `PPAT_ASSERT_IMP(a_online, clk_i, rst_ni, out_valid, is_online == (presence_out != 3'd0))
  `PPAT_ASSERT_IMP(a_rem_rng, clk_i, rst_ni, out_valid, removed_count <= 7'd64)
  `PPAT_ASSERT_NEXT(a_one_flight, clk_i, rst_ni, in_valid && in_ready, !in_ready)
  `PPAT_ASSERT_IMP(a_exp_nofound, clk_i, rst_ni, out_valid && removed_count != 7'd0, !found)
endmodule

bind peer_presence_aging_table ppat_checker u_chk (
  .clk_i, .rst_ni,
  .in_valid(req.valid), .in_ready(req.ready),
  .out_valid(rsp.valid), .out_ready(rsp.ready),
  .found(rsp.data.found), .presence_out(rsp.data.presence_out),
  .is_online(rsp.data.is_online), .removed_count(rsp.data.removed_count)
);
